@@ design/alarm_clock_mode_controller_defines.svh @@
// Assertion macros for the alarm clock mode controller.
// Used by the top level only; expects aclk and aresetn in scope.
`ifndef ALARM_CLOCK_MODE_CONTROLLER_DEFINES_SVH
`define ALARM_CLOCK_MODE_CONTROLLER_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define ACMC_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset.
`define ACMC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/acmc_pkg.sv @@
// Shared types, codes and helper functions for the alarm clock mode controller.
// No dependencies; imported by every module of the block.
package acmc_pkg;

    // mode codes
    localparam logic [2:0] MODE_STARTUP  = 3'd0;
    localparam logic [2:0] MODE_MAIN     = 3'd1;
    localparam logic [2:0] MODE_TIMESET  = 3'd2;
    localparam logic [2:0] MODE_ALARMSET = 3'd3;
    localparam logic [2:0] MODE_RINGING  = 3'd4;

    // request kinds
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_FRAME = 1'b1;

    // button bit positions
    localparam int BTN_S1 = 0;
    localparam int BTN_S2 = 1;
    localparam int BTN_S3 = 2;
    localparam int BTN_S4 = 3;
    localparam int BTN_L3 = 6;
    localparam int BTN_L4 = 7;

    // field select codes
    localparam logic [1:0] FIELD_HOURS   = 2'd0;
    localparam logic [1:0] FIELD_MINUTES = 2'd1;
    localparam logic [1:0] FIELD_SECONDS = 2'd2;
    localparam logic [1:0] FIELD_UNUSED  = 2'd3;
    localparam logic [2:0] NUM_FIELDS    = 3'd3;

    // register indexes (paddr bit 2)
    localparam logic REG_STARTUP_FRAMES = 1'b0;
    localparam logic REG_RING_TIMEOUT   = 1'b1;

    localparam logic [7:0] STARTUP_FRAMES_RST = 8'd10;
    localparam logic [7:0] RING_TIMEOUT_RST   = 8'd50;

    localparam logic [5:0] SECS_PER_MIN  = 6'd60;
    localparam logic [5:0] MINS_PER_HOUR = 6'd60;
    localparam logic [5:0] HOURS_PER_DAY = 6'd24;

    localparam logic [4:0] HOUR_RST       = 5'd18;
    localparam logic [5:0] MINUTE_RST     = 6'd15;
    localparam logic [4:0] ALARM_HOUR_RST = 5'd21;
    localparam logic [5:0] ALARM_MIN_RST  = 6'd35;

    typedef struct packed {
        logic [7:0] startup_frames;
        logic [7:0] ring_timeout_frames;
        logic       startup_wr;
        logic [7:0] wr_data;
    } cfg_t;

    typedef struct packed {
        logic [2:0] mode;
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic [4:0] alarm_hours;
        logic [5:0] alarm_minutes;
        logic [5:0] alarm_seconds;
        logic       alarm_enabled;
        logic       ringing;
        logic [1:0] field_select;
    } result_t;

    function automatic logic [5:0] wrap_up(input logic [5:0] v, input logic [5:0] limit);
        logic [6:0] inc;
        inc = {1'b0, v} + 7'd1;
        return (inc >= {1'b0, limit}) ? 6'd0 : inc[5:0];
    endfunction

    function automatic logic [5:0] wrap_down(input logic [5:0] v, input logic [5:0] limit);
        return (v == 6'd0 || v >= limit) ? limit - 6'd1 : v - 6'd1;
    endfunction

endpackage

@@ design/alarm_clock_mode_controller.sv @@
// Alarm clock mode controller: top level with request and result registers.
// Depends on acmc_pkg, acmc_apb_regs, acmc_state and the assertion macro header.
//
// Usage
// - Request channel (s_*): s_op 0 is a one-second tick, s_op 1 a button frame with
//   eight flags in s_buttons (short presses in bits 0-3, long presses in bits 6-7).
// - Result channel (m_*): exactly one result per request, showing mode, time,
//   alarm time, armed and ringing flags and the field being set, after the request.
// - APB port: register 0 (address 0) startup wait in frames, register 1
//   (address 4) ring timeout in frames. Writes only while the block is idle.
// - Path: an accepted request waits in the request register and moves into the result
//   register, where m_valid rises, once that register is empty or being drained.
// - Throughput: one request per cycle while results are taken; the state update is a
//   single pass of small compares and increments between the request and result registers.
// - Stalls: while m_ready is low the result holds, one more request may wait in
//   the request register, and s_ready then drops until the result is taken.
// - Reset (aresetn low, synchronous): startup mode, time 18:15:00, alarm
//   21:35:00, alarm disarmed, registers back to 10 and 50, both channels empty.
`include "alarm_clock_mode_controller_defines.svh"

module alarm_clock_mode_controller
    import acmc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [7:0]  s_buttons,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_mode,
    output logic [4:0]  m_hours,
    output logic [5:0]  m_minutes,
    output logic [5:0]  m_seconds,
    output logic [4:0]  m_alarm_hours,
    output logic [5:0]  m_alarm_minutes,
    output logic [5:0]  m_alarm_seconds,
    output logic        m_alarm_enabled,
    output logic        m_ringing,
    output logic [1:0]  m_field_select,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t    cfg;
    result_t res_next;
    result_t result_reg;

    logic       in_valid_reg;
    logic       op_reg;
    logic [7:0] buttons_reg;
    logic       m_valid_reg;
    logic       advance;

    // The held request moves on when the result register is empty or being drained.
    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // request register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg      <= s_op;
            buttons_reg <= s_buttons;
        end
    end

    acmc_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // state is committed as the request leaves the request register
    acmc_state u_state (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .item_fire (advance),
        .op        (op_reg),
        .buttons   (buttons_reg),
        .cfg       (cfg),
        .res_next  (res_next)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= res_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_mode          = result_reg.mode;
    assign m_hours         = result_reg.hours;
    assign m_minutes       = result_reg.minutes;
    assign m_seconds       = result_reg.seconds;
    assign m_alarm_hours   = result_reg.alarm_hours;
    assign m_alarm_minutes = result_reg.alarm_minutes;
    assign m_alarm_seconds = result_reg.alarm_seconds;
    assign m_alarm_enabled = result_reg.alarm_enabled;
    assign m_ringing       = result_reg.ringing;
    assign m_field_select  = result_reg.field_select;

    // ringing flag and ringing mode always travel together
    `ACMC_ASSERT_IMPLIES(a_ring_mode, m_valid_reg, m_ringing == (m_mode == MODE_RINGING), "ringing flag disagrees with mode")
    // field select never reaches the unused code
    `ACMC_ASSERT_IMPLIES(a_field_sel, m_valid_reg, m_field_select != FIELD_UNUSED, "unused field select in result")
    // time of day stays within range
    `ACMC_ASSERT_IMPLIES(a_time_range, m_valid_reg, ({1'b0, m_hours} < HOURS_PER_DAY) && (m_minutes < MINS_PER_HOUR) && (m_seconds < SECS_PER_MIN), "time of day out of range")
    // an accepted request is held in the request register next cycle
    `ACMC_ASSERT_NEXT(a_req_held, s_valid && s_ready, in_valid_reg, "accepted request lost")

endmodule

@@ design/acmc_apb_regs.sv @@
// APB configuration registers: startup wait and ring timeout.
// Depends on acmc_pkg for cfg_t and register indexes.
module acmc_apb_regs
    import acmc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    logic [7:0] startup_frames_reg;
    logic [7:0] ring_timeout_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            startup_frames_reg <= STARTUP_FRAMES_RST;
            ring_timeout_reg   <= RING_TIMEOUT_RST;
        end else if (wr_en) begin
            if (paddr[2] == REG_STARTUP_FRAMES) begin
                startup_frames_reg <= pwdata[7:0];
            end else begin
                ring_timeout_reg <= pwdata[7:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_RING_TIMEOUT) begin
            prdata = {24'd0, ring_timeout_reg};
        end else begin
            prdata = {24'd0, startup_frames_reg};
        end
    end

    assign cfg.startup_frames      = startup_frames_reg;
    assign cfg.ring_timeout_frames = ring_timeout_reg;
    assign cfg.startup_wr          = wr_en && (paddr[2] == REG_STARTUP_FRAMES);
    assign cfg.wr_data             = pwdata[7:0];

endmodule

@@ design/acmc_state.sv @@
// Clock, alarm and mode state with the per-request update logic.
// Depends on acmc_pkg for codes, cfg_t, result_t and wrap helpers.
module acmc_state
    import acmc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       item_fire,
    input  logic       op,
    input  logic [7:0] buttons,
    input  cfg_t       cfg,
    output result_t    res_next
);

    logic [2:0] mode_reg, mode_next;
    logic [7:0] frame_counter_reg, frame_counter_next;
    logic [1:0] sel_reg, sel_next;
    logic [4:0] hour_reg, hour_next;
    logic [5:0] minute_reg, minute_next;
    logic [5:0] second_reg, second_next;
    logic [4:0] alarm_hour_reg, alarm_hour_next;
    logic [5:0] alarm_minute_reg, alarm_minute_next;
    logic [5:0] alarm_second_reg, alarm_second_next;
    logic       armed_reg, armed_next;
    logic       ring_reg, ring_next;

    always_comb begin
        logic [6:0] sec_inc;
        logic [6:0] min_t;
        logic [6:0] hour_t;
        logic       is_alarm;
        logic [4:0] set_h;
        logic [5:0] set_m;
        logic [5:0] set_s;
        logic [5:0] tmp6;
        logic [2:0] sel_inc;
        logic [7:0] fc_dec;

        mode_next          = mode_reg;
        frame_counter_next = frame_counter_reg;
        sel_next           = sel_reg;
        hour_next          = hour_reg;
        minute_next        = minute_reg;
        second_next        = second_reg;
        alarm_hour_next    = alarm_hour_reg;
        alarm_minute_next  = alarm_minute_reg;
        alarm_second_next  = alarm_second_reg;
        armed_next         = armed_reg;
        ring_next          = ring_reg;

        sec_inc  = {1'b0, second_reg} + 7'd1;
        min_t    = {1'b0, minute_reg};
        hour_t   = {2'b00, hour_reg};
        is_alarm = (mode_reg == MODE_ALARMSET);
        set_h    = is_alarm ? alarm_hour_reg   : hour_reg;
        set_m    = is_alarm ? alarm_minute_reg : minute_reg;
        set_s    = is_alarm ? alarm_second_reg : second_reg;
        tmp6     = 6'd0;
        sel_inc  = {1'b0, sel_reg} + 3'd1;
        fc_dec   = frame_counter_reg - 8'd1;

        if (op == OP_TICK) begin
            // seconds carry into minutes, minutes into hours
            if (sec_inc >= {1'b0, SECS_PER_MIN}) begin
                second_next = 6'd0;
                min_t       = min_t + 7'd1;
            end else begin
                second_next = sec_inc[5:0];
            end
            if (min_t >= {1'b0, MINS_PER_HOUR}) begin
                min_t  = 7'd0;
                hour_t = hour_t + 7'd1;
            end
            if (hour_t >= {1'b0, HOURS_PER_DAY}) begin
                hour_t = 7'd0;
            end
            minute_next = min_t[5:0];
            hour_next   = hour_t[4:0];
        end else begin
            case (mode_reg)
                MODE_STARTUP: begin
                    if (frame_counter_reg != 8'd0) begin
                        frame_counter_next = fc_dec;
                    end else begin
                        mode_next = MODE_MAIN;
                    end
                end
                MODE_MAIN: begin
                    if (buttons[BTN_L4]) begin
                        mode_next = MODE_TIMESET;
                        sel_next  = FIELD_HOURS;
                    end
                    if (buttons[BTN_L3]) begin
                        mode_next = MODE_ALARMSET;
                        sel_next  = FIELD_HOURS;
                    end
                    armed_next = armed_reg ^ buttons[BTN_S2];
                    // match overrides a set-mode entry in the same frame
                    if (armed_next && hour_reg == alarm_hour_reg &&
                        minute_reg == alarm_minute_reg &&
                        second_reg == alarm_second_reg) begin
                        mode_next          = MODE_RINGING;
                        frame_counter_next = cfg.ring_timeout_frames;
                        ring_next          = 1'b1;
                    end
                end
                MODE_TIMESET, MODE_ALARMSET: begin
                    if (buttons[BTN_S4]) begin
                        mode_next = MODE_MAIN;
                    end
                    // down step first, then up step on its result
                    if (buttons[BTN_S1]) begin
                        case (sel_reg)
                            FIELD_HOURS: begin
                                tmp6  = wrap_down({1'b0, set_h}, HOURS_PER_DAY);
                                set_h = tmp6[4:0];
                            end
                            FIELD_MINUTES: set_m = wrap_down(set_m, MINS_PER_HOUR);
                            FIELD_SECONDS: begin
                                // time seconds clear rather than step
                                set_s = is_alarm ? wrap_down(set_s, SECS_PER_MIN) : 6'd0;
                            end
                            default: ;
                        endcase
                    end
                    if (buttons[BTN_S2]) begin
                        case (sel_reg)
                            FIELD_HOURS: begin
                                tmp6  = wrap_up({1'b0, set_h}, HOURS_PER_DAY);
                                set_h = tmp6[4:0];
                            end
                            FIELD_MINUTES: set_m = wrap_up(set_m, MINS_PER_HOUR);
                            FIELD_SECONDS: set_s = wrap_up(set_s, SECS_PER_MIN);
                            default: ;
                        endcase
                    end
                    if (buttons[BTN_S3]) begin
                        sel_next = (sel_inc >= NUM_FIELDS) ? FIELD_HOURS : sel_inc[1:0];
                    end
                    if (is_alarm) begin
                        alarm_hour_next   = set_h;
                        alarm_minute_next = set_m;
                        alarm_second_next = set_s;
                    end else begin
                        hour_next   = set_h;
                        minute_next = set_m;
                        second_next = set_s;
                    end
                end
                MODE_RINGING: begin
                    if (frame_counter_reg != 8'd0) begin
                        frame_counter_next = fc_dec;
                        if (fc_dec == 8'd0) begin
                            ring_next = 1'b0;
                            mode_next = MODE_MAIN;
                        end
                    end
                    if (buttons[BTN_S4]) begin
                        ring_next = 1'b0;
                        mode_next = MODE_MAIN;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg          <= MODE_STARTUP;
            frame_counter_reg <= STARTUP_FRAMES_RST;
            sel_reg           <= FIELD_HOURS;
            hour_reg          <= HOUR_RST;
            minute_reg        <= MINUTE_RST;
            second_reg        <= 6'd0;
            alarm_hour_reg    <= ALARM_HOUR_RST;
            alarm_minute_reg  <= ALARM_MIN_RST;
            alarm_second_reg  <= 6'd0;
            armed_reg         <= 1'b0;
            ring_reg          <= 1'b0;
        end else if (item_fire) begin
            mode_reg          <= mode_next;
            frame_counter_reg <= frame_counter_next;
            sel_reg           <= sel_next;
            hour_reg          <= hour_next;
            minute_reg        <= minute_next;
            second_reg        <= second_next;
            alarm_hour_reg    <= alarm_hour_next;
            alarm_minute_reg  <= alarm_minute_next;
            alarm_second_reg  <= alarm_second_next;
            armed_reg         <= armed_next;
            ring_reg          <= ring_next;
        end else if (cfg.startup_wr && mode_reg == MODE_STARTUP) begin
            // new startup wait restarts the countdown
            frame_counter_reg <= cfg.wr_data;
        end
    end

    assign res_next.mode          = mode_next;
    assign res_next.hours         = hour_next;
    assign res_next.minutes       = minute_next;
    assign res_next.seconds       = second_next;
    assign res_next.alarm_hours   = alarm_hour_next;
    assign res_next.alarm_minutes = alarm_minute_next;
    assign res_next.alarm_seconds = alarm_second_next;
    assign res_next.alarm_enabled = armed_next;
    assign res_next.ringing       = ring_next;
    assign res_next.field_select  = sel_next;

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the alarm clock mode controller: queued requests,
// a behavioural mirror of the clock state and a field-by-field result check.
// Depends on acmc_pkg and the alarm_clock_mode_controller RTL.
`timescale 1ns / 100ps

module tb_top;
    import acmc_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int RANDOM_ITEMS = 1650;
    localparam int NUM_SEGMENTS = 6;
    localparam int DAY_HOURS    = 24;
    localparam int HOUR_MINUTES = 60;   // same range for seconds in a minute
    localparam int MAX_PRINTED  = 50;

    // ring timeout per random segment; the fourth is replaced by a random value
    localparam logic [7:0] RING_SETTING [NUM_SEGMENTS] = '{8'd1, 8'd255, 8'd0, 8'd7, 8'd3, 8'd50};

    typedef struct packed {
        logic       op;
        logic [7:0] buttons;
    } clock_req_t;

    // Mirror of everything the block keeps, registers included
    typedef struct {
        logic [2:0] mode;
        logic [7:0] count;          // startup wait or ring timeout, depending on mode
        logic [1:0] field;
        logic [4:0] hrs;
        logic [5:0] mins;
        logic [5:0] secs;
        logic [4:0] al_hrs;
        logic [5:0] al_mins;
        logic [5:0] al_secs;
        logic       armed;
        logic       ring;
        logic [7:0] startup_frames;
        logic [7:0] ring_frames;
    } clock_state_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    logic        s_op      = 1'b0;
    logic [7:0]  s_buttons = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    logic [2:0]  m_mode;
    logic [4:0]  m_hours;
    logic [5:0]  m_minutes;
    logic [5:0]  m_seconds;
    logic [4:0]  m_alarm_hours;
    logic [5:0]  m_alarm_minutes;
    logic [5:0]  m_alarm_seconds;
    logic        m_alarm_enabled;
    logic        m_ringing;
    logic [1:0]  m_field_select;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;

    clock_req_t   request_q[$];   // requests waiting for the driver
    result_t      reading_q[$];   // predicted readings, oldest first
    clock_state_t shadow;         // mirror of the block, advanced on acceptance
    clock_state_t plan;           // mirror advanced as requests are queued
    int           err_count     = 0;
    int           cycles        = 0;
    int           queued        = 0;
    int           send_idle_pct = 38;
    int           recv_idle_pct = 85;

    alarm_clock_mode_controller i_dut (.*);

    initial begin
        forever #6 aclk = ~aclk;
    end

    // ---------------------------------------------------------------------
    // Behavioural model
    // ---------------------------------------------------------------------

    // One step of a wrapping counter with range 0..lim-1
    function automatic int roll(int v, int lim, bit up);
        if (up)
            return (v + 1 >= lim) ? 0 : v + 1;
        return (v == 0 || v >= lim) ? lim - 1 : v - 1;
    endfunction

    function automatic logic [7:0] press(int pos);
        logic [7:0] b;
        b = '0;
        b[pos] = 1'b1;
        return b;
    endfunction

    function automatic clock_state_t adjust_field(clock_state_t st, bit alarm, bit up);
        clock_state_t n;
        n = st;
        case (n.field)
            FIELD_HOURS:
                if (alarm) n.al_hrs = 5'(roll(n.al_hrs, DAY_HOURS, up));
                else       n.hrs    = 5'(roll(n.hrs, DAY_HOURS, up));
            FIELD_MINUTES:
                if (alarm) n.al_mins = 6'(roll(n.al_mins, HOUR_MINUTES, up));
                else       n.mins    = 6'(roll(n.mins, HOUR_MINUTES, up));
            FIELD_SECONDS:
                if (alarm) n.al_secs = 6'(roll(n.al_secs, HOUR_MINUTES, up));
                // a down step on the time's seconds clears them
                else       n.secs    = up ? 6'(roll(n.secs, HOUR_MINUTES, 1'b1)) : '0;
            default: ;
        endcase
        return n;
    endfunction

    // State after one request
    function automatic clock_state_t advance_clock(clock_state_t st, logic op,
                                                   logic [7:0] btn);
        clock_state_t n;
        bit           alarm;
        n = st;
        alarm = (st.mode == MODE_ALARMSET);
        if (op == OP_TICK) begin
            // buttons ignored, mode untouched, no alarm match on ticks
            n.secs = 6'(roll(n.secs, HOUR_MINUTES, 1'b1));
            if (n.secs == 0) begin
                n.mins = 6'(roll(n.mins, HOUR_MINUTES, 1'b1));
                if (n.mins == 0)
                    n.hrs = 5'(roll(n.hrs, DAY_HOURS, 1'b1));
            end
            return n;
        end
        case (st.mode)
            MODE_STARTUP: begin
                if (n.count != 0) n.count = n.count - 8'd1;
                else              n.mode  = MODE_MAIN;
            end
            MODE_MAIN: begin
                if (btn[BTN_L4]) begin
                    n.mode  = MODE_TIMESET;
                    n.field = FIELD_HOURS;
                end
                // long 3 wins over long 4
                if (btn[BTN_L3]) begin
                    n.mode  = MODE_ALARMSET;
                    n.field = FIELD_HOURS;
                end
                if (btn[BTN_S2])
                    n.armed = !n.armed;
                // a match overrides any set-mode entry in the same frame
                if (n.armed && n.hrs == n.al_hrs && n.mins == n.al_mins &&
                    n.secs == n.al_secs) begin
                    n.mode  = MODE_RINGING;
                    n.count = n.ring_frames;
                    n.ring  = 1'b1;
                end
            end
            MODE_TIMESET, MODE_ALARMSET: begin
                if (btn[BTN_S4]) n.mode = MODE_MAIN;
                if (btn[BTN_S1]) n = adjust_field(n, alarm, 1'b0);
                if (btn[BTN_S2]) n = adjust_field(n, alarm, 1'b1);
                if (btn[BTN_S3])
                    n.field = (n.field >= FIELD_SECONDS) ? FIELD_HOURS : n.field + 2'd1;
            end
            MODE_RINGING: begin
                // a zero timeout never expires; only short 4 ends it
                if (n.count != 0) begin
                    n.count = n.count - 8'd1;
                    if (n.count == 0) begin
                        n.ring = 1'b0;
                        n.mode = MODE_MAIN;
                    end
                end
                if (btn[BTN_S4]) begin
                    n.ring = 1'b0;
                    n.mode = MODE_MAIN;
                end
            end
            default: ;
        endcase
        return n;
    endfunction

    function automatic clock_state_t apply_reg(clock_state_t st, logic idx, logic [7:0] val);
        clock_state_t n;
        n = st;
        if (idx == REG_STARTUP_FRAMES) begin
            n.startup_frames = val;
            // a write during startup restarts the wait
            if (n.mode == MODE_STARTUP)
                n.count = val;
        end else begin
            n.ring_frames = val;
        end
        return n;
    endfunction

    function automatic int field_value(clock_state_t st, bit alarm, logic [1:0] f);
        case (f)
            FIELD_HOURS:   return alarm ? st.al_hrs : st.hrs;
            FIELD_MINUTES: return alarm ? st.al_mins : st.mins;
            default:       return alarm ? st.al_secs : st.secs;
        endcase
    endfunction

    // ---------------------------------------------------------------------
    // Request generation: the plan mirror tells each sequence where it stands
    // ---------------------------------------------------------------------

    function automatic void push_request(logic op, logic [7:0] btn);
        request_q.push_back(clock_req_t'{op: op, buttons: btn});
        plan = advance_clock(plan, op, btn);
        queued++;
    endfunction

    // long presses are ignored in the set modes, so they make free noise there
    function automatic logic [7:0] hi_noise();
        return {4'($urandom_range(15)), 4'b0000};
    endfunction

    function automatic void go_main();
        while (plan.mode != MODE_MAIN)
            push_request(OP_FRAME, (plan.mode == MODE_RINGING) ?
                press(BTN_S4) | 8'($urandom_range(255)) : press(BTN_S4) | hi_noise());
    endfunction

    // Walk one field of the current set mode to a target value
    function automatic void steer(bit alarm, logic [1:0] f, int target);
        int cur;
        int lim;
        lim = (f == FIELD_HOURS) ? DAY_HOURS : HOUR_MINUTES;
        while (plan.field != f)
            push_request(OP_FRAME, press(BTN_S3) | hi_noise());
        cur = field_value(plan, alarm, f);
        while (cur != target) begin
            if (!alarm && f == FIELD_SECONDS)
                // time seconds only go down by clearing, then climb
                push_request(OP_FRAME, press(target < cur ? BTN_S1 : BTN_S2) | hi_noise());
            else
                push_request(OP_FRAME, press((target - cur + lim) % lim <= lim / 2 ?
                                             BTN_S2 : BTN_S1) | hi_noise());
            cur = field_value(plan, alarm, f);
        end
    endfunction

    // Set the alarm a few seconds ahead, arm, let it match and ring
    function automatic void ring_scenario();
        clock_state_t ahead;
        logic [7:0]   quiet;
        int           lead;
        int           n;
        quiet = ~(press(BTN_S2) | press(BTN_L3) | press(BTN_L4));
        go_main();
        push_request(OP_FRAME, 8'($urandom_range(255)) | press(BTN_L3));
        if (plan.mode != MODE_ALARMSET)
            return;
        lead = $urandom_range(0, 6);
        ahead = plan;
        repeat (lead) ahead = advance_clock(ahead, OP_TICK, '0);
        steer(1'b1, FIELD_HOURS, ahead.hrs);
        steer(1'b1, FIELD_MINUTES, ahead.mins);
        steer(1'b1, FIELD_SECONDS, ahead.secs);
        push_request(OP_FRAME, press(BTN_S4) | hi_noise());
        if (!plan.armed)
            push_request(OP_FRAME, press(BTN_S2) | (8'($urandom_range(255)) & quiet));
        repeat (lead) push_request(OP_TICK, 8'($urandom_range(255)));
        if (plan.mode != MODE_RINGING)
            push_request(OP_FRAME, 8'($urandom_range(255)) & quiet);
        // acknowledge at once: the match still holds, so it rings again
        if (plan.mode == MODE_RINGING && $urandom_range(3) == 0) begin
            push_request(OP_FRAME, press(BTN_S4) | hi_noise());
            push_request(OP_FRAME, 8'($urandom_range(255)) & quiet);
        end
        n = $urandom_range(1, 40);
        while (plan.mode == MODE_RINGING && n > 0) begin
            if ($urandom_range(7) == 0)
                push_request(OP_TICK, 8'($urandom_range(255)));
            else if ($urandom_range(19) == 0)
                push_request(OP_FRAME, 8'($urandom_range(255)) | press(BTN_S4));
            else
                push_request(OP_FRAME, 8'($urandom_range(255)) & ~press(BTN_S4));
            n--;
        end
    endfunction

    // Enter a set mode, then either steer all fields or press at random
    function automatic void set_scenario();
        logic [7:0] b;
        bit         alarm;
        bit         to_midnight;
        go_main();
        alarm = 1'($urandom_range(1));
        b = (8'($urandom_range(255)) & ~press(BTN_L3)) | press(alarm ? BTN_L3 : BTN_L4);
        push_request(OP_FRAME, b);
        if (plan.mode != (alarm ? MODE_ALARMSET : MODE_TIMESET))
            return;
        to_midnight = 1'b0;
        if ($urandom_range(2) == 0) begin
            to_midnight = !alarm && ($urandom_range(1) == 1);
            steer(alarm, FIELD_HOURS,
                  to_midnight ? DAY_HOURS - 1 : int'($urandom_range(DAY_HOURS - 1)));
            steer(alarm, FIELD_MINUTES,
                  to_midnight ? HOUR_MINUTES - 1 : int'($urandom_range(HOUR_MINUTES - 1)));
            steer(alarm, FIELD_SECONDS,
                  to_midnight ? int'($urandom_range(45, 59)) :
                                int'($urandom_range(HOUR_MINUTES - 1)));
        end else begin
            repeat ($urandom_range(1, 12)) begin
                b = 8'($urandom_range(255));
                if ($urandom_range(9) != 0)
                    b &= ~press(BTN_S4);
                push_request(OP_FRAME, b);
            end
        end
        go_main();
        // carry through to the next day
        if (to_midnight)
            repeat ($urandom_range(15, 30)) push_request(OP_TICK, 8'($urandom_range(255)));
    endfunction

    // ---------------------------------------------------------------------
    // Configuration port and flow control helpers
    // ---------------------------------------------------------------------

    task automatic write_reg(logic idx, logic [7:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, val};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        // register takes the value at this edge; nothing is in flight
        shadow = apply_reg(shadow, idx, val);
        plan   = apply_reg(plan, idx, val);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Sender holds off until every result is home, then a latency margin
    task automatic wait_drained();
        while (request_q.size() != 0 || s_valid || reading_q.size() != 0)
            @(negedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
        err_count++;
        if (err_count <= MAX_PRINTED)
            $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    task automatic check_reading(result_t got, result_t want);
        if (got.mode !== want.mode)
            report_mismatch("mode", got.mode, want.mode);
        if (got.hours !== want.hours)
            report_mismatch("hours", got.hours, want.hours);
        if (got.minutes !== want.minutes)
            report_mismatch("minutes", got.minutes, want.minutes);
        if (got.seconds !== want.seconds)
            report_mismatch("seconds", got.seconds, want.seconds);
        if (got.alarm_hours !== want.alarm_hours)
            report_mismatch("alarm_hours", got.alarm_hours, want.alarm_hours);
        if (got.alarm_minutes !== want.alarm_minutes)
            report_mismatch("alarm_minutes", got.alarm_minutes, want.alarm_minutes);
        if (got.alarm_seconds !== want.alarm_seconds)
            report_mismatch("alarm_seconds", got.alarm_seconds, want.alarm_seconds);
        if (got.alarm_enabled !== want.alarm_enabled)
            report_mismatch("alarm_enabled", got.alarm_enabled, want.alarm_enabled);
        if (got.ringing !== want.ringing)
            report_mismatch("ringing", got.ringing, want.ringing);
        if (got.field_select !== want.field_select)
            report_mismatch("field_select", got.field_select, want.field_select);
    endtask

    // ---------------------------------------------------------------------
    // Driver, result acceptor, monitor and watchdog
    // ---------------------------------------------------------------------

    // A request stays put until taken; a fresh one may follow in the same edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                {s_op, s_buttons} <= request_q.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        m_ready <= aresetn && ($urandom_range(99) >= recv_idle_pct);
    end

    // Results are checked before the request of the same edge is predicted;
    // a request's result can never be taken at its own acceptance edge
    always @(posedge aclk) begin : monitor
        result_t got;
        result_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got = {m_mode, m_hours, m_minutes, m_seconds, m_alarm_hours,
                       m_alarm_minutes, m_alarm_seconds, m_alarm_enabled, m_ringing,
                       m_field_select};
                if (reading_q.size() == 0) begin
                    report_mismatch("result with none outstanding", 8'd1, 8'd0);
                end else begin
                    want = reading_q.pop_front();
                    check_reading(got, want);
                end
            end
            if (s_valid && s_ready) begin
                shadow = advance_clock(shadow, s_op, s_buttons);
                reading_q.push_back({shadow.mode, shadow.hrs, shadow.mins, shadow.secs,
                                     shadow.al_hrs, shadow.al_mins, shadow.al_secs,
                                     shadow.armed, shadow.ring, shadow.field});
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------

    initial begin : stimulus
        int seg_end;
        int pick;
        shadow = '{mode: MODE_STARTUP, count: STARTUP_FRAMES_RST, field: FIELD_HOURS,
                   hrs: HOUR_RST, mins: MINUTE_RST, secs: '0,
                   al_hrs: ALARM_HOUR_RST, al_mins: ALARM_MIN_RST, al_secs: '0,
                   armed: 1'b0, ring: 1'b0,
                   startup_frames: STARTUP_FRAMES_RST, ring_frames: RING_TIMEOUT_RST};
        plan = shadow;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Startup: count down a little, restart the wait at the top value,
        // then cut it to zero so the next frame reaches main mode
        push_request(OP_FRAME, 8'hFF);
        push_request(OP_FRAME, 8'h00);
        wait_drained();
        write_reg(REG_STARTUP_FRAMES, 8'd255);
        push_request(OP_FRAME, 8'h00);
        push_request(OP_TICK, 8'hFF);
        wait_drained();
        write_reg(REG_STARTUP_FRAMES, 8'd0);
        push_request(OP_FRAME, 8'hFF);

        // Main: arm, disarm, then both long presses (alarm set wins)
        push_request(OP_FRAME, press(BTN_S2));
        push_request(OP_FRAME, press(BTN_S2));
        push_request(OP_TICK, 8'h00);
        push_request(OP_FRAME, press(BTN_L3) | press(BTN_L4));

        // Alarm set: hours stepped both ways, minutes and seconds down, alarm seconds down from zero
        push_request(OP_FRAME, press(BTN_S2));
        push_request(OP_FRAME, press(BTN_S1));
        push_request(OP_FRAME, press(BTN_S1) | press(BTN_S2));
        push_request(OP_FRAME, press(BTN_S3));
        push_request(OP_FRAME, press(BTN_S1));
        push_request(OP_FRAME, press(BTN_S3));
        push_request(OP_FRAME, press(BTN_S1));
        push_request(OP_FRAME, press(BTN_S3));
        // everything at once: back to main after the steps and field change
        push_request(OP_FRAME, 8'hFF);

        // Time set: seconds up, then the clearing down step
        push_request(OP_FRAME, press(BTN_L4));
        push_request(OP_FRAME, press(BTN_S3));
        push_request(OP_FRAME, press(BTN_S3));
        push_request(OP_FRAME, press(BTN_S2));
        push_request(OP_FRAME, press(BTN_S1));
        push_request(OP_FRAME, press(BTN_S4));
        push_request(OP_TICK, 8'h00);
        wait_drained();

        // Random segments: heavy result stalls, then heavy request gaps, then none
        for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
            send_idle_pct = (seg < 2) ? 38 : (seg < 4) ? 85 : 0;
            recv_idle_pct = (seg < 2) ? 85 : (seg < 4) ? 38 : 0;
            write_reg(REG_RING_TIMEOUT,
                      (seg == 3) ? 8'($urandom_range(2, 20)) : RING_SETTING[seg]);
            write_reg(REG_STARTUP_FRAMES, 8'($urandom_range(255)));
            seg_end = queued + RANDOM_ITEMS / NUM_SEGMENTS;
            while (queued < seg_end) begin
                pick = $urandom_range(99);
                if (pick < 30)
                    ring_scenario();
                else if (pick < 55)
                    set_scenario();
                else if (pick < 80)
                    repeat ($urandom_range(1, 20))
                        push_request(OP_TICK, 8'($urandom_range(255)));
                else
                    repeat ($urandom_range(1, 10))
                        push_request(1'($urandom_range(1)), 8'($urandom_range(255)));
            end
            wait_drained();
        end

        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
